/* hw/rtl/lmsp_pkg.sv */
// ----------------------------------------------------------------------------
// lmsp_pkg - shared definitions for the LED matrix scan PWM block
// Widths, reset values, register indexes and the slot wait table.
// ----------------------------------------------------------------------------
package lmsp_pkg;

   localparam int LEVEL_BITS_DEF  = 4;
   localparam int MATRIX_SIZE_DEF = 8;

   localparam int MULT_W     = 6;   // wait multiplier register
   localparam int WAIT_W     = 14;  // per-column wait counter
   localparam int BASE_W     = 8;   // base table entries
   localparam int BASE_IDX_W = 6;   // slot index into base table (widest level)
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam logic [MULT_W-1:0] MULT_RESET = MULT_W'(5);
   localparam logic              BANK_RESET = 1'b0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WAIT_MULT    = 1'b0,
      CSR_DISPLAY_BANK = 1'b1
   } csr_index_type;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_PIXEL = 1'b1;

   // base wait per slot; slots past the table use the last entry
   function automatic logic [BASE_W-1:0] base_wait(input logic [BASE_IDX_W-1:0] idx);
      logic [BASE_W-1:0] val;
      unique case (idx)
         6'd0:    val = 8'd0;
         6'd1:    val = 8'd10;
         6'd2:    val = 8'd12;
         6'd3:    val = 8'd15;
         6'd4:    val = 8'd18;
         6'd5:    val = 8'd22;
         6'd6:    val = 8'd27;
         6'd7:    val = 8'd33;
         6'd8:    val = 8'd39;
         6'd9:    val = 8'd47;
         6'd10:   val = 8'd56;
         6'd11:   val = 8'd68;
         6'd12:   val = 8'd82;
         6'd13:   val = 8'd100;
         6'd14:   val = 8'd120;
         default: val = 8'd150;
      endcase
      return val;
   endfunction

endpackage

/* hw/rtl/lmsp_req_if.sv */
// ----------------------------------------------------------------------------
// lmsp_req_if - input item channel
// Valid/ready channel carrying ticks and pixel writes.
// ----------------------------------------------------------------------------
interface lmsp_req_if #(
   parameter int MATRIX_SIZE = lmsp_pkg::MATRIX_SIZE_DEF,
   parameter int LEVEL_BITS  = lmsp_pkg::LEVEL_BITS_DEF
);
   localparam int IDX_W = $clog2(MATRIX_SIZE);

   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic                  write_bank;
   logic [IDX_W-1:0]      write_row;
   logic [IDX_W-1:0]      write_col;
   logic [LEVEL_BITS-1:0] write_level;

   modport source (
      output valid, mode, write_bank, write_row, write_col, write_level,
      input  ready
   );
   modport sink (
      input  valid, mode, write_bank, write_row, write_col, write_level,
      output ready
   );
endinterface

/* hw/rtl/lmsp_rsp_if.sv */
// ----------------------------------------------------------------------------
// lmsp_rsp_if - result item channel
// Valid/ready channel carrying the column and row drive of each item.
// ----------------------------------------------------------------------------
interface lmsp_rsp_if #(
   parameter int MATRIX_SIZE = lmsp_pkg::MATRIX_SIZE_DEF,
   parameter int LEVEL_BITS  = lmsp_pkg::LEVEL_BITS_DEF
);
   localparam int IDX_W = $clog2(MATRIX_SIZE);

   logic                   valid;
   logic                   ready;
   logic [MATRIX_SIZE-1:0] column_drive;
   logic [MATRIX_SIZE-1:0] row_drive;
   logic [IDX_W-1:0]       column_index;
   logic [LEVEL_BITS-1:0]  slot_index;
   logic                   frame_done;

   modport source (
      output valid, column_drive, row_drive, column_index, slot_index, frame_done,
      input  ready
   );
   modport sink (
      input  valid, column_drive, row_drive, column_index, slot_index, frame_done,
      output ready
   );
endinterface

/* hw/rtl/lmsp_fbuf.sv */
// ----------------------------------------------------------------------------
// lmsp_fbuf - framebuffer memory
// One word per (bank, column) holding every row's level. Per-lane pixel
// writes, registered read, same-edge write forwarding, clear pass on reset.
// ----------------------------------------------------------------------------
module lmsp_fbuf #(
   parameter int MATRIX_SIZE = lmsp_pkg::MATRIX_SIZE_DEF,
   parameter int LEVEL_BITS  = lmsp_pkg::LEVEL_BITS_DEF,
   localparam int IDX_W      = $clog2(MATRIX_SIZE),
   localparam int ADDR_W     = IDX_W + 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rd_en,
   input  logic [ADDR_W-1:0]                      rd_addr,
   input  logic                                   wr_en,
   input  logic [ADDR_W-1:0]                      wr_addr,
   input  logic [IDX_W-1:0]                       wr_row,
   input  logic [LEVEL_BITS-1:0]                  wr_level,
   output logic                                   clr_busy,
   output logic [MATRIX_SIZE-1:0][LEVEL_BITS-1:0] rd_word
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [MATRIX_SIZE-1:0][LEVEL_BITS-1:0] mem [DEPTH];

   logic [ADDR_W:0]                        clr_cnt_ff, clr_cnt_in;
   logic [MATRIX_SIZE-1:0][LEVEL_BITS-1:0] rd_ff;
   logic                                   fwd_hit_ff;
   logic [IDX_W-1:0]                       fwd_row_ff;
   logic [LEVEL_BITS-1:0]                  fwd_level_ff;

   assign clr_busy   = !clr_cnt_ff[ADDR_W];
   assign clr_cnt_in = clr_busy ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // one write port: whole word during clear, one lane otherwise
   always_ff @(posedge clock) begin
      if (clr_busy) begin
         mem[clr_cnt_ff[ADDR_W-1:0]] <= '0;
      end else if (wr_en) begin
         mem[wr_addr][wr_row] <= wr_level;
      end
   end

   // read data is old on a same-edge write; keep the write to patch it
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff        <= mem[rd_addr];
         fwd_hit_ff   <= wr_en && (wr_addr == rd_addr);
         fwd_row_ff   <= wr_row;
         fwd_level_ff <= wr_level;
      end
   end

   always_comb begin
      rd_word = rd_ff;
      if (fwd_hit_ff) begin
         rd_word[fwd_row_ff] = fwd_level_ff;
      end
   end

endmodule

/* hw/rtl/lmsp_scan.sv */
// ----------------------------------------------------------------------------
// lmsp_scan - column and slot sequencer
// Wait counter against base table times multiplier; steps slot and column.
// ----------------------------------------------------------------------------
module lmsp_scan #(
   parameter int MATRIX_SIZE = lmsp_pkg::MATRIX_SIZE_DEF,
   parameter int LEVEL_BITS  = lmsp_pkg::LEVEL_BITS_DEF,
   localparam int IDX_W      = $clog2(MATRIX_SIZE)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          tick,
   input  logic [lmsp_pkg::MULT_W-1:0]   wait_mult,
   output logic [IDX_W-1:0]              col,
   output logic [LEVEL_BITS-1:0]         slot,
   output logic                          done
);

   localparam logic [LEVEL_BITS-1:0] SLOT_FIRST = LEVEL_BITS'(1);
   localparam logic [LEVEL_BITS-1:0] SLOT_LAST  = {LEVEL_BITS{1'b1}};
   localparam logic [IDX_W-1:0]      COL_LAST   = IDX_W'(MATRIX_SIZE - 1);

   logic [IDX_W-1:0]              col_ff, col_in;
   logic [LEVEL_BITS-1:0]         slot_ff, slot_in;
   logic [lmsp_pkg::WAIT_W-1:0]   wait_ff, wait_in;
   logic [lmsp_pkg::WAIT_W-1:0]   thresh;
   logic                          stay, last_slot, last_col;

   assign thresh = lmsp_pkg::WAIT_W'(lmsp_pkg::base_wait(lmsp_pkg::BASE_IDX_W'(slot_ff)))
                 * lmsp_pkg::WAIT_W'(wait_mult);
   assign stay      = wait_ff < thresh;
   assign last_slot = slot_ff == SLOT_LAST;
   assign last_col  = col_ff == COL_LAST;
   assign done      = !stay && last_slot && last_col;

   always_comb begin
      col_in  = col_ff;
      slot_in = slot_ff;
      wait_in = wait_ff;
      if (tick) begin
         wait_in = wait_ff + 1'b1;
         if (!stay) begin
            if (last_slot) begin
               slot_in = SLOT_FIRST;
               wait_in = '0;
               col_in  = last_col ? '0 : col_ff + 1'b1;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         slot_ff <= SLOT_FIRST;
         wait_ff <= '0;
      end else begin
         col_ff  <= col_in;
         slot_ff <= slot_in;
         wait_ff <= wait_in;
      end
   end

   assign col  = col_ff;
   assign slot = slot_ff;

endmodule

/* hw/rtl/lmsp_out.sv */
// ----------------------------------------------------------------------------
// lmsp_out - row compare and result buffering
// Holds item data beside the memory read, forms the drive word, and feeds
// an output register with a skid entry.
// ----------------------------------------------------------------------------
module lmsp_out #(
   parameter int MATRIX_SIZE = lmsp_pkg::MATRIX_SIZE_DEF,
   parameter int LEVEL_BITS  = lmsp_pkg::LEVEL_BITS_DEF,
   localparam int IDX_W      = $clog2(MATRIX_SIZE)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  logic [IDX_W-1:0]                       col,
   input  logic [LEVEL_BITS-1:0]                  slot,
   input  logic                                   done,
   input  logic [MATRIX_SIZE-1:0][LEVEL_BITS-1:0] rd_word,
   output logic                                   can_take,
   lmsp_rsp_if.source                             rsp
);

   typedef struct packed {
      logic [MATRIX_SIZE-1:0] column_drive;
      logic [MATRIX_SIZE-1:0] row_drive;
      logic [IDX_W-1:0]       column_index;
      logic [LEVEL_BITS-1:0]  slot_index;
      logic                   frame_done;
   } rsp_type;

   logic                  s1_v_ff, s1_v_in;
   logic [IDX_W-1:0]      s1_col_ff;
   logic [LEVEL_BITS-1:0] s1_slot_ff;
   logic                  s1_done_ff;
   logic                  out_v_ff, out_v_in;
   logic                  sk_v_ff, sk_v_in;
   rsp_type               out_ff, sk_ff, s1_pay;
   logic                  s1_move, out_open;

   always_comb begin
      s1_pay.column_drive = MATRIX_SIZE'(1) << s1_col_ff;
      for (int r = 0; r < MATRIX_SIZE; r++) begin
         s1_pay.row_drive[r] = rd_word[r] >= s1_slot_ff;
      end
      s1_pay.column_index = s1_col_ff;
      s1_pay.slot_index   = s1_slot_ff;
      s1_pay.frame_done   = s1_done_ff;
   end

   assign can_take = !s1_v_ff || !sk_v_ff;
   assign s1_move  = s1_v_ff && !sk_v_ff;
   assign out_open = rsp.ready || !out_v_ff;

   always_comb begin
      s1_v_in  = load || (s1_v_ff && !s1_move);
      out_v_in = out_v_ff;
      sk_v_in  = sk_v_ff;
      if (out_open) begin
         if (sk_v_ff) begin
            out_v_in = 1'b1;
            sk_v_in  = 1'b0;
         end else begin
            out_v_in = s1_move;
         end
      end else if (s1_move) begin
         sk_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else begin
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
         sk_v_ff  <= sk_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_col_ff  <= col;
         s1_slot_ff <= slot;
         s1_done_ff <= done;
      end
      if (out_open) begin
         out_ff <= sk_v_ff ? sk_ff : s1_pay;
      end else if (s1_move) begin
         sk_ff <= s1_pay;
      end
   end

   assign rsp.valid        = out_v_ff;
   assign rsp.column_drive = out_ff.column_drive;
   assign rsp.row_drive    = out_ff.row_drive;
   assign rsp.column_index = out_ff.column_index;
   assign rsp.slot_index   = out_ff.slot_index;
   assign rsp.frame_done   = out_ff.frame_done;

endmodule

/* hw/rtl/led_matrix_scan_pwm_top.sv */
// ----------------------------------------------------------------------------
// led_matrix_scan_pwm_top - column-scan PWM engine for an LED matrix
// Framebuffer of two banks, slot/column sequencer and result buffering.
// ----------------------------------------------------------------------------
// Each request item is either a tick (mode 0, one check of the scan wait
// loop) or a pixel write (mode 1) into one of two framebuffer banks. Every
// item gives exactly one result: the column and row drive as they stood
// before a tick's update, or as they stand after a pixel write. The block
// takes one item per clock while req_ch.ready is high; a result is held
// in the framebuffer read register and then the output register, and a
// skid entry lets one more item in when the result side stalls.
// The framebuffer is a single memory of 2 x 2^clog2(MATRIX_SIZE) words,
// one word per bank and column with all rows' levels, so one read per item
// gives the whole row drive. After reset a clearing pass zeroes it, one
// word per clock (16 words at the default size), during which req_ch.ready
// is low. Writes to rows or columns past the matrix are dropped. Register
// writes (csr_*) take effect on the next clock and should be made while
// no item is in flight.
// ----------------------------------------------------------------------------
module led_matrix_scan_pwm_top #(
   parameter int MATRIX_SIZE = lmsp_pkg::MATRIX_SIZE_DEF,
   parameter int LEVEL_BITS  = lmsp_pkg::LEVEL_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [lmsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lmsp_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   lmsp_req_if.sink                            req_ch,
   lmsp_rsp_if.source                          rsp_ch
);

   localparam int IDX_W  = $clog2(MATRIX_SIZE);
   localparam int ADDR_W = IDX_W + 1;

   // configuration registers
   logic [lmsp_pkg::MULT_W-1:0] mult_ff;
   logic                        bank_ff;

   logic                                   accept, is_pixel, tick, in_range, wr_en;
   logic                                   clr_busy, can_take;
   logic [IDX_W-1:0]                       scan_col;
   logic [LEVEL_BITS-1:0]                  scan_slot;
   logic                                   scan_done;
   logic [ADDR_W-1:0]                      rd_addr, wr_addr;
   logic [MATRIX_SIZE-1:0][LEVEL_BITS-1:0] rd_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff <= lmsp_pkg::MULT_RESET;
         bank_ff <= lmsp_pkg::BANK_RESET;
      end else if (csr_wr_en) begin
         unique case (lmsp_pkg::csr_index_type'(csr_index))
            lmsp_pkg::CSR_WAIT_MULT:    mult_ff <= csr_wr_data[lmsp_pkg::MULT_W-1:0];
            lmsp_pkg::CSR_DISPLAY_BANK: bank_ff <= csr_wr_data[0];
         endcase
      end
   end

   // no item while the clear pass runs or the buffers are full
   assign req_ch.ready = !clr_busy && can_take;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_pixel     = req_ch.mode == lmsp_pkg::MODE_PIXEL;
   assign tick         = accept && (req_ch.mode == lmsp_pkg::MODE_TICK);

   // only matters when MATRIX_SIZE is not a power of two
   assign in_range = ({1'b0, req_ch.write_row} < (IDX_W + 1)'(MATRIX_SIZE))
                  && ({1'b0, req_ch.write_col} < (IDX_W + 1)'(MATRIX_SIZE));
   assign wr_en    = accept && is_pixel && in_range;

   // shown bank at the active column; write addresses its own bank/column
   assign rd_addr = {bank_ff, scan_col};
   assign wr_addr = {req_ch.write_bank, req_ch.write_col};

   lmsp_fbuf #(
      .MATRIX_SIZE (MATRIX_SIZE),
      .LEVEL_BITS  (LEVEL_BITS)
   ) u_fbuf (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (rd_addr),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_row   (req_ch.write_row),
      .wr_level (req_ch.write_level),
      .clr_busy (clr_busy),
      .rd_word  (rd_word)
   );

   lmsp_scan #(
      .MATRIX_SIZE (MATRIX_SIZE),
      .LEVEL_BITS  (LEVEL_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .tick      (tick),
      .wait_mult (mult_ff),
      .col       (scan_col),
      .slot      (scan_slot),
      .done      (scan_done)
   );

   // frame_done only on a tick; a pixel write never ends a frame
   lmsp_out #(
      .MATRIX_SIZE (MATRIX_SIZE),
      .LEVEL_BITS  (LEVEL_BITS)
   ) u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .col      (scan_col),
      .slot     (scan_slot),
      .done     (tick && scan_done),
      .rd_word  (rd_word),
      .can_take (can_take),
      .rsp      (rsp_ch)
   );

`ifndef SYNTHESIS
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy |-> !req_ch.ready)
      else $error("item taken during framebuffer clear");

   a_col_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> $onehot(rsp_ch.column_drive))
      else $error("column drive not one-hot");

   a_done_at_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.frame_done) |->
         (rsp_ch.column_index == IDX_W'(MATRIX_SIZE - 1))
         && (rsp_ch.slot_index == {LEVEL_BITS{1'b1}}))
      else $error("frame_done away from last column and slot");

   a_wrap_to_first: assert property (@(posedge clock) disable iff (reset)
      (tick && scan_done) |=> (scan_col == '0) && (scan_slot == LEVEL_BITS'(1)))
      else $error("scan did not wrap after frame end");
`endif

endmodule
